// ===== src/aes_pkg.sv =====
// Package for the AES block cipher unit: state machine type, S-box tables
// and GF(2^8) helpers. No dependencies.
package aes_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_INIT,
      ST_ROUND,
      ST_DONE
   } state_type;

   localparam logic [1:0] MODE_128 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;
   localparam logic [1:0] MODE_256 = 2'd2;

   localparam logic [2:0] CSR_MODE = 3'd0;
   localparam logic [2:0] CSR_KEY0 = 3'd1;
   localparam logic [2:0] CSR_KEY1 = 3'd2;
   localparam logic [2:0] CSR_KEY2 = 3'd3;
   localparam logic [2:0] CSR_KEY3 = 3'd4;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1b;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] REV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      subst_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
   endfunction

   // Forward MixColumns on one column, row 0 in the top byte
   function automatic logic [31:0] mix_fwd(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      mix_fwd = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // Inverse MixColumns: premultiply by {04}x^2+{05}, then forward mix
   function automatic logic [31:0] mix_rev(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      mix_rev = mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

endpackage

// ===== src/aes_block_cipher_unit.sv =====
// AES cipher / inverse cipher unit, 128/192/256-bit keys.
// Each request first expands the key schedule into the round-key store, then,
// for each of the Nr+1 key additions, fetches four key words (the store read is
// registered), assembles them into the round key and applies it.
// A new request is accepted only in idle, after the previous result is taken;
// the round datapath is reused for every round.
// Reset (synchronous, active high) clears the sequencer, mode and key registers.
// Depends on aes_pkg.
module aes_block_cipher_unit #(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int AW = $clog2(ROUND_KEY_WORDS);

   aes_pkg::state_type state_ff, state_in;

   logic [1:0]   mode_ff;
   logic [63:0]  key_ff [4];
   logic [AW-1:0] wi_ff, wi_in;        // schedule word index
   logic [3:0]   round_ff, round_in;
   logic [3:0]   nr_ff, nr_in;
   logic [3:0]   nk_ff, nk_in;
   logic [2:0]   kpos_ff, kpos_in;     // i mod nk
   logic [7:0]   rc_ff, rc_in;
   logic         act_ff;
   logic [127:0] st_ff, st_in;
   logic [255:0] win_ff, win_in;      // last eight schedule words, newest low
   logic [1:0]   col_ff, col_in;      // column of round key being fetched
   logic [127:0] rk_ff;               // assembled round key
   logic         rk_ok_ff;

   logic [31:0]  mem [ROUND_KEY_WORDS];
   logic [31:0]  rd_ff;
   logic         we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0]  wdata;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= aes_pkg::MODE_128;
         for (int k = 0; k < 4; k++) key_ff[k] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            aes_pkg::CSR_MODE: mode_ff   <= csr_data[1:0];
            aes_pkg::CSR_KEY0: key_ff[0] <= csr_data;
            aes_pkg::CSR_KEY1: key_ff[1] <= csr_data;
            aes_pkg::CSR_KEY2: key_ff[2] <= csr_data;
            aes_pkg::CSR_KEY3: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective key length, clipped to what the store holds
   logic [3:0] nk_sel;
   always_comb begin
      nk_sel = (mode_ff == aes_pkg::MODE_128) ? 4'd4 :
               (mode_ff == aes_pkg::MODE_192) ? 4'd6 : 4'd8;
      if (nk_sel == 4'd8 && 4 * (8 + 7) > ROUND_KEY_WORDS) nk_sel = 4'd6;
      if (nk_sel == 4'd6 && 4 * (6 + 7) > ROUND_KEY_WORDS) nk_sel = 4'd4;
   end

   // Schedule word generator: one word per cycle from the window
   logic [31:0] prev, back, t, key_word;
   logic [AW:0] total;
   always_comb begin
      prev = win_ff[31:0];
      back = (nk_ff == 4'd4) ? win_ff[127:96] :
             (nk_ff == 4'd6) ? win_ff[191:160] : win_ff[255:224];
      t = prev;
      if (kpos_ff == 3'd0)
         t = aes_pkg::subst_word({prev[23:0], prev[31:24]}) ^ {rc_ff, 24'h0};
      else if (nk_ff == 4'd8 && kpos_ff == 3'd4)
         t = aes_pkg::subst_word(prev);
      key_word = wi_ff[0] ? key_ff[wi_ff[2:1]][31:0] : key_ff[wi_ff[2:1]][63:32];
      total = (AW+1)'(4 * (32'(nr_ff) + 1));
   end

   // Round unit: one full round per cycle, combinational; a round is applied only once its round key has been fetched
   logic [127:0] sb, sh, mx, ark, isr, isb, imx;
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         sb[127-8*k -: 8] = aes_pkg::FWD_BOX[st_ff[127-8*k -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sh[127-8*(r+4*c) -: 8]  = sb[127-8*(r+4*((c+r)%4)) -: 8];
            isr[127-8*(r+4*((c+r)%4)) -: 8] = st_ff[127-8*(r+4*c) -: 8];
         end
      end
      for (int k = 0; k < 16; k++) begin
         isb[127-8*k -: 8] = aes_pkg::REV_BOX[isr[127-8*k -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         mx[127-32*c -: 32] = aes_pkg::mix_fwd(sh[127-32*c -: 32]);
      end
      ark = isb ^ rk_ff;
      for (int c = 0; c < 4; c++) begin
         imx[127-32*c -: 32] = aes_pkg::mix_rev(ark[127-32*c -: 32]);
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      wi_in    = wi_ff;
      round_in = round_ff;
      nr_in    = nr_ff;
      nk_in    = nk_ff;
      kpos_in  = kpos_ff;
      rc_in    = rc_ff;
      st_in    = st_ff;
      win_in   = win_ff;
      col_in   = col_ff;
      we       = 1'b0;
      waddr    = wi_ff;
      wdata    = key_word;
      raddr    = {AW{1'b0}};
      req_ready = (state_ff == aes_pkg::ST_IDLE);
      rsp_valid = (state_ff == aes_pkg::ST_DONE);
      unique case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = aes_pkg::ST_KEY;
               st_in    = {req_block_hi, req_block_lo};
               nk_in    = nk_sel;
               nr_in    = nk_sel + 4'd6;
               wi_in    = '0;
               kpos_in  = '0;
               rc_in    = aes_pkg::RCON_FIRST;
            end
         end
         aes_pkg::ST_KEY: begin
            // emit schedule word wi
            we = 1'b1;
            if (wi_ff >= AW'(nk_ff)) begin
               wdata = back ^ t;
               if (kpos_ff == 3'd0) rc_in = aes_pkg::xtime(rc_ff);
            end
            win_in = {win_ff[223:0], wdata};
            if (wi_ff >= AW'(nk_ff))
               kpos_in = (kpos_ff + 3'd1 == nk_ff[2:0] || kpos_ff + 3'd1 == 3'd0 && nk_ff == 4'd8)
                         ? 3'd0 : kpos_ff + 3'd1;
            else if (wi_ff == AW'(nk_ff - 4'd1))
               kpos_in = 3'd0;
            if ({1'b0, wi_ff} + 1'b1 == total) begin
               state_in = aes_pkg::ST_INIT;
               round_in = act_ff ? nr_ff : 4'd0;
               col_in   = '0;
            end else begin
               wi_in = wi_ff + 1'b1;
            end
         end
         aes_pkg::ST_INIT, aes_pkg::ST_ROUND: begin
            // fetch four key words of this round, then apply it
            raddr = AW'({round_ff, col_ff});
            col_in = col_ff + 2'd1;
            if (rk_ok_ff) begin
               col_in = '0;
               if (state_ff == aes_pkg::ST_INIT) begin
                  st_in    = st_ff ^ rk_ff;
                  state_in = aes_pkg::ST_ROUND;
                  round_in = act_ff ? nr_ff - 4'd1 : 4'd1;
               end else if (!act_ff) begin
                  st_in = ((round_ff == nr_ff) ? sh : mx) ^ rk_ff;
                  if (round_ff == nr_ff) state_in = aes_pkg::ST_DONE;
                  else round_in = round_ff + 4'd1;
               end else begin
                  st_in = (round_ff == 4'd0) ? ark : imx;
                  if (round_ff == 4'd0) state_in = aes_pkg::ST_DONE;
                  else round_in = round_ff - 4'd1;
               end
            end
         end
         aes_pkg::ST_DONE: begin
            if (rsp_ready) state_in = aes_pkg::ST_IDLE;
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   // Round key assembly tracks read latency: a word arrives in the cycle after its address
   logic [2:0] fetch_ff;
   always_ff @(posedge clock) begin
      if (reset || !(state_ff == aes_pkg::ST_INIT || state_ff == aes_pkg::ST_ROUND)
          || rk_ok_ff) begin
         fetch_ff <= '0;
         rk_ok_ff <= 1'b0;
      end else begin
         if (fetch_ff != 3'd0) rk_ff <= {rk_ff[95:0], rd_ff};
         fetch_ff <= fetch_ff + 3'd1;
         rk_ok_ff <= (fetch_ff == 3'd4);
      end
   end

   // Round-key memory
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // State and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aes_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == aes_pkg::ST_IDLE && req_valid) act_ff <= req_action;
      wi_ff    <= wi_in;
      round_ff <= round_in;
      nr_ff    <= nr_in;
      nk_ff    <= nk_in;
      kpos_ff  <= kpos_in;
      rc_ff    <= rc_in;
      st_ff    <= st_in;
      win_ff   <= win_in;
      col_ff   <= col_in;
   end

   assign rsp_result_hi = st_ff[127:64];
   assign rsp_result_lo = st_ff[63:0];

   // Checks
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready and result together");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_hi))
      else $error("result dropped");
   a_nr: assert property (@(posedge clock) disable iff (reset)
      state_ff == aes_pkg::ST_ROUND |-> round_ff <= nr_ff)
      else $error("round out of range");

endmodule
